>>> design/mhks_pkg.sv
// shared constants, codes and types for the modulo hash key set
package mhks_pkg;

    localparam int KEY_W            = 31;
    localparam int CFG_W            = 9;
    localparam int OP_W             = 2;
    localparam int CNT_W            = $clog2(KEY_W);
    localparam int MAX_BUCKETS_DEF  = 256;
    localparam int SLOTS_DEF        = 4;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = CFG_W'(11);

    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_CMP
    } state_t;

endpackage

>>> design/mhks_ram.sv
// generic single-port ram with registered read
module mhks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/mhks_div.sv
// bit-serial remainder unit: one key bit per cycle
module mhks_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [mhks_pkg::KEY_W-1:0] dividend,
    input  logic [mhks_pkg::CFG_W-1:0] modulus,
    output logic                     done,
    output logic [mhks_pkg::CFG_W-1:0] remainder
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [mhks_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [mhks_pkg::KEY_W-1:0]    dvd_reg, dvd_next;
    logic [mhks_pkg::CFG_W-1:0]    mod_reg, mod_next;
    logic [mhks_pkg::CFG_W-1:0]    rem_reg, rem_next;
    logic [mhks_pkg::CFG_W:0]      trial;
    logic [mhks_pkg::CFG_W:0]      mod_ext;
    logic [mhks_pkg::CFG_W-1:0]    rem_step;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[cnt_reg]};
        mod_ext  = {1'b0, mod_reg};
        rem_step = (trial >= mod_ext) ? mhks_pkg::CFG_W'(trial - mod_ext)
                                      : mhks_pkg::CFG_W'(trial);

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        mod_next  = mod_reg;
        rem_next  = rem_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = mhks_pkg::CNT_W'(mhks_pkg::KEY_W - 1);
            dvd_next  = dividend;
            mod_next  = modulus;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = rem_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        mod_reg <= mod_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> design/modulo_hash_key_set_unit.sv
// top level of the modulo hash key set: fsm, bucket row memory and remainder unit
//
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------
//  command   start / busy               op, key
//  result    done (one-cycle strobe)    found, status
//  config    cfg_valid / cfg_ready      bucket_count
//
// an item passes through 31 steps in the bit-serial remainder unit, one bucket row read
// and one write-back, then returns to the idle state, which shows the done strobe and
// can take the next item
// after reset the block sweeps MAX_BUCKETS rows to clear them, busy held high
// config writes are taken at any time (cfg_ready is always high)
// results cannot be stalled; done pulses for one cycle per item
module modulo_hash_key_set_unit #(
    parameter int MAX_BUCKETS      = mhks_pkg::MAX_BUCKETS_DEF,
    parameter int SLOTS_PER_BUCKET = mhks_pkg::SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mhks_pkg::OP_W-1:0]   op,
    input  logic [mhks_pkg::KEY_W-1:0]  key,
    output logic                        done,
    output logic                        found,
    output logic                        status,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [mhks_pkg::CFG_W-1:0]  bucket_count
);

    localparam int BKT_W     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int SLOT_W    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int SLOT_BITS = mhks_pkg::KEY_W + 1;
    localparam int ROW_W     = SLOTS_PER_BUCKET * SLOT_BITS;
    localparam logic [BKT_W-1:0] LAST_ROW = BKT_W'(MAX_BUCKETS - 1);
    localparam logic [mhks_pkg::CFG_W-1:0] MOD_CLAMP = mhks_pkg::CFG_W'(MAX_BUCKETS);

    mhks_pkg::state_t               state_reg, state_next;
    logic [mhks_pkg::CFG_W-1:0]     bucket_count_reg;
    logic [mhks_pkg::OP_W-1:0]      op_reg, op_next;
    logic [mhks_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [BKT_W-1:0]               clr_reg, clr_next;
    logic [BKT_W-1:0]               bucket_reg, bucket_next;
    logic                           done_reg, done_next;
    logic                           found_reg, found_next;
    logic                           status_reg, status_next;

    logic [mhks_pkg::CFG_W-1:0]     eff_mod;
    logic                           div_start;
    logic                           div_done;
    logic [mhks_pkg::CFG_W-1:0]     div_rem;

    logic                           mem_we;
    logic [BKT_W-1:0]               mem_addr;
    logic [ROW_W-1:0]               mem_wdata;
    logic [ROW_W-1:0]               mem_rdata;

    logic [SLOTS_PER_BUCKET-1:0]    match;
    logic [SLOTS_PER_BUCKET-1:0]    empty;
    logic                           any_hit;
    logic                           any_free;
    logic [SLOT_W-1:0]              hit_idx;
    logic [SLOT_W-1:0]              free_idx;
    logic                           do_ins;
    logic                           do_rem;
    logic [ROW_W-1:0]               new_row;

    // effective modulus: zero taken as one, clamp to the table size
    always_comb
    begin
        if (bucket_count_reg == '0)
        begin
            eff_mod = mhks_pkg::CFG_W'(1);
        end
        else if (32'(bucket_count_reg) > MAX_BUCKETS)
        begin
            eff_mod = MOD_CLAMP;
        end
        else
        begin
            eff_mod = bucket_count_reg;
        end
    end

    mhks_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (key),
        .modulus   (eff_mod),
        .done      (div_done),
        .remainder (div_rem)
    );

    mhks_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_BUCKETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // slot compare over the bucket row
    always_comb
    begin
        any_hit  = 1'b0;
        any_free = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < SLOTS_PER_BUCKET; i++)
        begin
            empty[i] = !mem_rdata[i*SLOT_BITS + mhks_pkg::KEY_W];
            match[i] = !empty[i] &&
                       (mem_rdata[i*SLOT_BITS +: mhks_pkg::KEY_W] == key_reg);
        end
        for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                any_hit = 1'b1;
                hit_idx = SLOT_W'(i);
            end
            if (empty[i])
            begin
                any_free = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
        do_ins  = (op_reg == mhks_pkg::OP_INSERT) && !any_hit && any_free;
        do_rem  = (op_reg == mhks_pkg::OP_REMOVE) && any_hit;
        new_row = mem_rdata;
        for (int i = 0; i < SLOTS_PER_BUCKET; i++)
        begin
            if (do_ins && (free_idx == SLOT_W'(i)))
            begin
                new_row[i*SLOT_BITS +: SLOT_BITS] = {1'b1, key_reg};
            end
            if (do_rem && (hit_idx == SLOT_W'(i)))
            begin
                new_row[i*SLOT_BITS + mhks_pkg::KEY_W] = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        clr_next    = clr_reg;
        bucket_next = bucket_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        status_next = status_reg;
        div_start   = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = bucket_reg;
        mem_wdata   = new_row;

        unique case (state_reg)
            mhks_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_ROW)
                begin
                    state_next = mhks_pkg::ST_IDLE;
                end
            end
            mhks_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = op;
                    key_next   = key;
                    div_start  = 1'b1;
                    state_next = mhks_pkg::ST_DIV;
                end
            end
            mhks_pkg::ST_DIV:
            begin
                mem_addr = BKT_W'(div_rem);
                if (div_done)
                begin
                    bucket_next = BKT_W'(div_rem);
                    state_next  = mhks_pkg::ST_CMP;
                end
            end
            mhks_pkg::ST_CMP:
            begin
                mem_we      = 1'b1;
                done_next   = 1'b1;
                found_next  = any_hit;
                status_next = ((op_reg == mhks_pkg::OP_INSERT) && !any_hit && !any_free)
                              ? mhks_pkg::STATUS_FULL : mhks_pkg::STATUS_DONE;
                state_next  = mhks_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mhks_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mhks_pkg::ST_CLEAR;
            clr_reg          <= '0;
            bucket_count_reg <= mhks_pkg::BUCKET_COUNT_RESET;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                bucket_count_reg <= bucket_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        bucket_reg <= bucket_next;
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign busy      = (state_reg != mhks_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign found     = found_reg;
    assign status    = status_reg;

endmodule

>>> design/mhks_chk.sv
// port-level checker for the modulo hash key set, bound to the top level
module mhks_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic found,
    input logic status
);

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without an item in flight");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("more than one result for an item");

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        done && status |-> !found)
        else $error("full bucket reported for a present key");

endmodule

bind modulo_hash_key_set_unit mhks_chk u_mhks_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .found  (found),
    .status (status)
);

>>> tb/sv/tb_modulo_hash_key_set_unit.sv
// self-checking testbench for the modulo hash key set unit
module tb_modulo_hash_key_set_unit;

    localparam logic [mhks_pkg::OP_W-1:0] OP_SPARE = 2'd3;
    localparam int SLOT_DEPTH = mhks_pkg::MAX_BUCKETS_DEF * mhks_pkg::SLOTS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int POOL_MAX = 48;

    typedef struct packed {
        logic found;
        logic status;
    } lookup_result_t;

    class key_set_scoreboard;
        logic [mhks_pkg::KEY_W-1:0] slot_key[SLOT_DEPTH];
        bit                         slot_used[SLOT_DEPTH];
        logic [mhks_pkg::CFG_W-1:0] modulus_reg;
        lookup_result_t             pending_results[$];
        int                         errors;

        function new();
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            foreach (slot_key[i]) slot_key[i] = '0;
            modulus_reg = mhks_pkg::BUCKET_COUNT_RESET;
            errors = 0;
        endfunction

        function int hash_modulus();
            int m;
            m = modulus_reg;
            if (m == 0) m = 1;
            if (m > mhks_pkg::MAX_BUCKETS_DEF) m = mhks_pkg::MAX_BUCKETS_DEF;
            return m;
        endfunction

        function void set_bucket_count(logic [mhks_pkg::CFG_W-1:0] value);
            modulus_reg = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // work out the set update and the answer for one accepted item
        function void note_command(logic [mhks_pkg::OP_W-1:0] cmd,
                                   logic [mhks_pkg::KEY_W-1:0] k);
            int base;
            int hit;
            int free_slot;
            lookup_result_t res;
            base = int'(k % mhks_pkg::KEY_W'(hash_modulus())) * mhks_pkg::SLOTS_DEF;
            hit = -1;
            free_slot = -1;
            res = '0;
            for (int i = 0; i < mhks_pkg::SLOTS_DEF; i++)
            begin
                if (slot_used[base + i])
                begin
                    if (hit < 0 && slot_key[base + i] == k) hit = base + i;
                end
                else if (free_slot < 0)
                begin
                    free_slot = base + i;
                end
            end
            res.found = (hit >= 0);
            res.status = mhks_pkg::STATUS_DONE;
            if (cmd == mhks_pkg::OP_INSERT && hit < 0)
            begin
                if (free_slot >= 0)
                begin
                    slot_key[free_slot] = k;
                    slot_used[free_slot] = 1'b1;
                end
                else
                begin
                    res.status = mhks_pkg::STATUS_FULL;
                end
            end
            else if (cmd == mhks_pkg::OP_REMOVE && hit >= 0)
            begin
                slot_used[hit] = 1'b0;
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(logic f, logic s);
            lookup_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: found %0d status %0d", f, s);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (f !== exp_res.found)
            begin
                $error("found mismatch: expected %0d actual %0d", exp_res.found, f);
                errors++;
            end
            if (s !== exp_res.status)
            begin
                $error("status mismatch: expected %0d actual %0d", exp_res.status, s);
                errors++;
            end
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic [mhks_pkg::OP_W-1:0]  op;
    logic [mhks_pkg::KEY_W-1:0] key;
    logic                       done;
    logic                       found;
    logic                       status;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [mhks_pkg::CFG_W-1:0] bucket_count;

    key_set_scoreboard          sb;
    int                         cycle_count;
    bit                         no_idle;
    logic [mhks_pkg::KEY_W-1:0] key_pool[$];

    modulo_hash_key_set_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .key          (key),
        .done         (done),
        .found        (found),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .bucket_count (bucket_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // results first: a new item's answer never lands on its own accept edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done) sb.check_result(found, status);
            if (start && !busy) sb.note_command(op, key);
            if (cfg_valid && cfg_ready) sb.set_bucket_count(bucket_count);
        end
    end

    task automatic send_item(input logic [mhks_pkg::OP_W-1:0] cmd,
                             input logic [mhks_pkg::KEY_W-1:0] k);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 19)
            gap = ($urandom_range(3) == 0) ? $urandom_range(1, 45) : $urandom_range(1, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op <= cmd;
        key <= k;
        do @(posedge clk); while (busy);
    endtask

    task automatic write_bucket_count(input logic [mhks_pkg::CFG_W-1:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        bucket_count <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [mhks_pkg::KEY_W-1:0] pick_key();
        int sel;
        logic [mhks_pkg::KEY_W-1:0] k;
        sel = $urandom_range(99);
        if (key_pool.size() == 0 || sel < 25)
            k = mhks_pkg::KEY_W'($urandom());
        else if (sel < 70)
            k = key_pool[$urandom_range(key_pool.size() - 1)];
        else
            // same bucket as a known key, to fill buckets up
            k = key_pool[$urandom_range(key_pool.size() - 1)]
                + mhks_pkg::KEY_W'(sb.hash_modulus() * $urandom_range(1, 6));
        return k;
    endfunction

    task automatic run_random(input int count);
        int sel;
        logic [mhks_pkg::OP_W-1:0] cmd;
        logic [mhks_pkg::KEY_W-1:0] k;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            if (sel < 40) cmd = mhks_pkg::OP_INSERT;
            else if (sel < 70) cmd = mhks_pkg::OP_FIND;
            else if (sel < 95) cmd = mhks_pkg::OP_REMOVE;
            else cmd = OP_SPARE;
            k = pick_key();
            if (cmd == mhks_pkg::OP_INSERT)
            begin
                key_pool.push_back(k);
                if (key_pool.size() > POOL_MAX) void'(key_pool.pop_front());
            end
            send_item(cmd, k);
        end
    endtask

    initial
    begin
        logic [mhks_pkg::CFG_W-1:0] settings[];
        settings = '{9'd0, 9'd1, 9'd10, 9'd257, 9'd511, 9'd256,
                     9'd13, 9'd11, 9'd97, 9'd2, 9'd251};
        sb = new();
        no_idle <= 1'b0;
        rst_n <= 1'b0;
        start <= 1'b0;
        op <= mhks_pkg::OP_FIND;
        key <= '0;
        cfg_valid <= 1'b0;
        bucket_count <= mhks_pkg::BUCKET_COUNT_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at the reset modulus
        send_item(mhks_pkg::OP_FIND, 31'd0);
        send_item(mhks_pkg::OP_INSERT, 31'd0);
        send_item(mhks_pkg::OP_INSERT, 31'd0);
        send_item(mhks_pkg::OP_INSERT, 31'd11);
        send_item(mhks_pkg::OP_INSERT, 31'd22);
        send_item(mhks_pkg::OP_INSERT, 31'd33);
        send_item(mhks_pkg::OP_INSERT, 31'd44);
        send_item(mhks_pkg::OP_FIND, 31'd44);
        send_item(mhks_pkg::OP_INSERT, 31'h7FFF_FFFF);
        send_item(mhks_pkg::OP_FIND, 31'h7FFF_FFFF);
        send_item(mhks_pkg::OP_REMOVE, 31'd5);
        send_item(mhks_pkg::OP_REMOVE, 31'd22);
        send_item(OP_SPARE, 31'd11);
        send_item(OP_SPARE, 31'd22);
        send_item(mhks_pkg::OP_INSERT, 31'd44);
        send_item(mhks_pkg::OP_FIND, 31'd22);
        send_item(mhks_pkg::OP_REMOVE, 31'h7FFF_FFFF);
        send_item(mhks_pkg::OP_INSERT, 31'h2AAA_AAAA);
        send_item(mhks_pkg::OP_INSERT, 31'h5555_5555);
        send_item(mhks_pkg::OP_FIND, 31'h2AAA_AAAA);

        foreach (settings[p])
        begin
            write_bucket_count(settings[p]);
            no_idle <= (p == 5);
            run_random(ITEMS_PER_PHASE);
        end

        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
design/mhks_pkg.sv
design/mhks_ram.sv
design/mhks_div.sv
design/modulo_hash_key_set_unit.sv
design/mhks_chk.sv
tb/sv/tb_modulo_hash_key_set_unit.sv
